### design/rsb_pkg.sv
// ============================================================================
// rsb_pkg
// Shared types and constants for the restart supervisor backoff unit.
// ============================================================================
`default_nettype none

package rsb_pkg;

    localparam int unsigned WAIT_BITS_DEFAULT = 16;
    localparam int unsigned CFG_BITS          = 16;
    localparam int unsigned APB_ADDR_BITS     = 4;
    localparam int unsigned APB_DATA_BITS     = 32;

    localparam logic [CFG_BITS-1:0] MIN_WAIT_RST = 16'd2;
    localparam logic [CFG_BITS-1:0] MAX_WAIT_RST = 16'd300;
    localparam int unsigned         RESET_WAIT   = 2;
    localparam int unsigned         FAIL_WAIT    = 60;

    localparam logic [1:0] REG_MIN_WAIT    = 2'd0;
    localparam logic [1:0] REG_MAX_WAIT    = 2'd1;
    localparam logic [1:0] REG_DAEMON_MODE = 2'd2;

    typedef enum logic [2:0] {
        EV_LAUNCH    = 3'd0,
        EV_TIMER     = 3'd1,
        EV_EXIT      = 3'd2,
        EV_HANGUP    = 3'd3,
        EV_INTERRUPT = 3'd4,
        EV_TERMINATE = 3'd5,
        EV_PAUSE     = 3'd6,
        EV_RESUME    = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_SIGNAL = 3'd2,
        ACT_TIMER  = 3'd3,
        ACT_EXIT   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        SIG_HANGUP    = 2'd0,
        SIG_INTERRUPT = 2'd1,
        SIG_TERMINATE = 2'd2
    } sig_t;

    typedef struct packed {
        logic running;
        logic restart_en;
        logic exit_pending;
        logic halted;
    } flags_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] min_wait;
        logic [CFG_BITS-1:0] max_wait;
        logic                daemon_mode;
    } cfg_t;

    typedef struct packed {
        action_t             action;
        sig_t                signal_kind;
        logic [CFG_BITS-1:0] timer_seconds;
        logic                exit_code;
        logic                worker_running;
    } result_t;

endpackage

`default_nettype wire

### design/rsb_in_if.sv
// ============================================================================
// rsb_in_if
// Event channel: valid/ready handshake carrying one supervisor event.
// ============================================================================
`default_nettype none

interface rsb_in_if;

    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic       start_ok;

    modport source (output valid, output mode, output start_ok, input ready);
    modport sink   (input valid, input mode, input start_ok, output ready);

endinterface

`default_nettype wire

### design/rsb_out_if.sv
// ============================================================================
// rsb_out_if
// Action channel: valid/ready handshake carrying one supervisor action.
// ============================================================================
`default_nettype none

interface rsb_out_if;

    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [1:0]  signal_kind;
    logic [15:0] timer_seconds;
    logic        exit_code;
    logic        worker_running;

    modport source (
        output valid, output action, output signal_kind, output timer_seconds,
        output exit_code, output worker_running, input ready
    );
    modport sink (
        input valid, input action, input signal_kind, input timer_seconds,
        input exit_code, input worker_running, output ready
    );

endinterface

`default_nettype wire

### design/rsb_step.sv
// ============================================================================
// rsb_step
// Next-state and action logic for one supervisor event, including the
// saturating wait doubling.
// ============================================================================
`default_nettype none

module rsb_step
    import rsb_pkg::*;
#(
    parameter int unsigned WAIT_BITS = WAIT_BITS_DEFAULT
) (
    input  wire  event_t               mode,
    input  wire  logic                 start_ok,
    input  wire  cfg_t                 cfg,
    input  wire  flags_t               flags,
    input  wire  logic [WAIT_BITS-1:0] cur_wait,
    output flags_t                     flags_next,
    output logic [WAIT_BITS-1:0]       wait_next,
    output result_t                    result
);

    localparam int unsigned EXT_BITS = (WAIT_BITS > CFG_BITS) ? WAIT_BITS : CFG_BITS;

    function automatic logic [WAIT_BITS-1:0] clamp_cfg(input logic [CFG_BITS-1:0] v);
        logic [EXT_BITS-1:0] ext;
        logic [EXT_BITS-1:0] lim;
        ext = EXT_BITS'(v);
        lim = EXT_BITS'({WAIT_BITS{1'b1}});
        if (ext > lim)
        begin
            ext = lim;
        end
        return ext[WAIT_BITS-1:0];
    endfunction

    logic [CFG_BITS-1:0]  emax_cfg;
    logic [WAIT_BITS-1:0] emax;
    logic [WAIT_BITS:0]   doubled;
    logic [WAIT_BITS-1:0] wait_doubled;
    logic [WAIT_BITS-1:0] secs_w;
    logic [EXT_BITS-1:0]  secs_ext;

    always_comb
    begin
        emax_cfg     = (cfg.max_wait < cfg.min_wait) ? cfg.min_wait : cfg.max_wait;
        emax         = clamp_cfg(emax_cfg);
        doubled      = {cur_wait, 1'b0};
        wait_doubled = (doubled >= {1'b0, emax}) ? emax : doubled[WAIT_BITS-1:0];
        secs_w       = (cur_wait == '0) ? WAIT_BITS'(1) : cur_wait;
        secs_ext     = EXT_BITS'(secs_w);
    end

    always_comb
    begin
        flags_next            = flags;
        wait_next             = cur_wait;
        result.action         = ACT_NONE;
        result.signal_kind    = SIG_HANGUP;
        result.timer_seconds  = '0;
        result.exit_code      = 1'b0;

        if (mode == EV_LAUNCH)
        begin
            flags_next.restart_en   = 1'b1;
            flags_next.exit_pending = 1'b0;
            flags_next.halted       = 1'b0;
            flags_next.running      = start_ok;
            wait_next     = start_ok ? clamp_cfg(cfg.min_wait) : WAIT_BITS'(FAIL_WAIT);
            result.action = ACT_START;
        end
        else if (!flags.halted)
        begin
            case (mode)
                EV_TIMER:
                begin
                    if (flags.exit_pending)
                    begin
                        result.action     = ACT_EXIT;
                        result.exit_code  = 1'b1;
                        flags_next.halted = 1'b1;
                    end
                    else if (flags.restart_en && !flags.running)
                    begin
                        result.action      = ACT_START;
                        flags_next.running = start_ok;
                        if (!start_ok)
                        begin
                            wait_next = WAIT_BITS'(FAIL_WAIT);
                        end
                    end
                end
                EV_EXIT:
                begin
                    flags_next.running = 1'b0;
                    if (flags.exit_pending)
                    begin
                        result.action     = ACT_EXIT;
                        flags_next.halted = 1'b1;
                    end
                    else if (flags.restart_en)
                    begin
                        result.action        = ACT_TIMER;
                        result.timer_seconds = secs_ext[CFG_BITS-1:0];
                        wait_next            = wait_doubled;
                    end
                end
                EV_HANGUP:
                begin
                    if (cfg.daemon_mode)
                    begin
                        if (flags.running)
                        begin
                            result.action = ACT_SIGNAL;
                        end
                    end
                    else if (flags.running)
                    begin
                        result.action           = ACT_SIGNAL;
                        flags_next.restart_en   = 1'b0;
                        flags_next.exit_pending = 1'b1;
                    end
                    else
                    begin
                        result.action     = ACT_EXIT;
                        result.exit_code  = 1'b1;
                        flags_next.halted = 1'b1;
                    end
                end
                EV_INTERRUPT, EV_TERMINATE:
                begin
                    if (!flags.running)
                    begin
                        result.action     = ACT_EXIT;
                        result.exit_code  = 1'b1;
                        flags_next.halted = 1'b1;
                    end
                    else
                    begin
                        result.action           = ACT_SIGNAL;
                        result.signal_kind      = (mode == EV_INTERRUPT) ? SIG_INTERRUPT
                                                                         : SIG_TERMINATE;
                        flags_next.restart_en   = 1'b0;
                        flags_next.exit_pending = 1'b1;
                    end
                end
                EV_PAUSE:
                begin
                    flags_next.restart_en = 1'b0;
                end
                EV_RESUME:
                begin
                    flags_next.restart_en = 1'b1;
                    if (!flags.running)
                    begin
                        result.action      = ACT_START;
                        flags_next.running = start_ok;
                        if (!start_ok)
                        begin
                            wait_next = WAIT_BITS'(FAIL_WAIT);
                        end
                    end
                end
                default:
                begin
                    result.action = ACT_NONE;
                end
            endcase
        end

        result.worker_running = flags_next.running;
    end

endmodule

`default_nettype wire

### design/restart_supervisor_backoff_unit.sv
// ============================================================================
// restart_supervisor_backoff_unit
// Restart supervisor with exponential backoff: one action per event.
// ============================================================================
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    mode, start_ok
//  out_ch    out  valid/ready    action, signal_kind, timer_seconds,
//                                exit_code, worker_running
//  apb       in   psel/penable   paddr, pwdata -> prdata (pready tied high)
//
//  One event per cycle while out_ch does not stall: an event enters the
//  input register, then flag update and saturating doubling fill the
//  result register, which loads when it is empty or out_ch accepts.
//  While a result waits on out_ch, the input register takes one more event
//  and then holds in_ch.ready low until out_ch accepts.
//  Reset clears running, exit-pending and halted, sets restart-enable,
//  loads the wait with 2 and restores the registers.
// ============================================================================
`default_nettype none

module restart_supervisor_backoff_unit
    import rsb_pkg::*;
#(
    parameter int unsigned WAIT_BITS = WAIT_BITS_DEFAULT
) (
    input  wire  logic                     clk,
    input  wire  logic                     rst_n,
    input  wire  logic                     psel,
    input  wire  logic                     penable,
    input  wire  logic                     pwrite,
    input  wire  logic [APB_ADDR_BITS-1:0] paddr,
    input  wire  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]       prdata,
    output logic                           pready,
    rsb_in_if.sink                         in_ch,
    rsb_out_if.source                      out_ch
);

    cfg_t                 cfg_reg;
    flags_t               flags_reg;
    flags_t               flags_next;
    logic [WAIT_BITS-1:0] wait_reg;
    logic [WAIT_BITS-1:0] wait_next;

    logic                 in_valid_reg;
    event_t               in_mode_reg;
    logic                 in_ok_reg;

    logic                 out_valid_reg;
    result_t              out_result_reg;
    result_t              result_next;

    logic                 advance;
    logic                 cfg_write;
    logic [1:0]           reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_wait    <= MIN_WAIT_RST;
            cfg_reg.max_wait    <= MAX_WAIT_RST;
            cfg_reg.daemon_mode <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_MIN_WAIT:    cfg_reg.min_wait    <= pwdata[CFG_BITS-1:0];
                REG_MAX_WAIT:    cfg_reg.max_wait    <= pwdata[CFG_BITS-1:0];
                REG_DAEMON_MODE: cfg_reg.daemon_mode <= pwdata[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MIN_WAIT:    prdata = APB_DATA_BITS'(cfg_reg.min_wait);
            REG_MAX_WAIT:    prdata = APB_DATA_BITS'(cfg_reg.max_wait);
            REG_DAEMON_MODE: prdata = APB_DATA_BITS'(cfg_reg.daemon_mode);
            default:         prdata = '0;
        endcase
    end

    rsb_step #(
        .WAIT_BITS (WAIT_BITS)
    ) u_step (
        .mode       (in_mode_reg),
        .start_ok   (in_ok_reg),
        .cfg        (cfg_reg),
        .flags      (flags_reg),
        .cur_wait   (wait_reg),
        .flags_next (flags_next),
        .wait_next  (wait_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            flags_reg.running      <= 1'b0;
            flags_reg.restart_en   <= 1'b1;
            flags_reg.exit_pending <= 1'b0;
            flags_reg.halted       <= 1'b0;
            wait_reg              <= WAIT_BITS'(RESET_WAIT);
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
                wait_reg      <= wait_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_mode_reg <= event_t'(in_ch.mode);
            in_ok_reg   <= in_ch.start_ok;
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.action         = out_result_reg.action;
    assign out_ch.signal_kind    = out_result_reg.signal_kind;
    assign out_ch.timer_seconds  = out_result_reg.timer_seconds;
    assign out_ch.exit_code      = out_result_reg.exit_code;
    assign out_ch.worker_running = out_result_reg.worker_running;

    a_halted_is_quiet: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && flags_reg.halted && (in_mode_reg != EV_LAUNCH)
            |=> out_result_reg.action == ACT_NONE
    ) else $error("event after halt produced an action");

    a_exit_sets_halt: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_result_reg.action == ACT_EXIT) |-> flags_reg.halted
    ) else $error("exit action without halted flag");

    a_launch_starts: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && (in_mode_reg == EV_LAUNCH)
            |=> (out_result_reg.action == ACT_START) && !flags_reg.halted
    ) else $error("launch did not start the worker");

endmodule

`default_nettype wire
